// File: rtl/core/ckt_pkg.sv
// Shared types and constants for the chord keyboard timing unit.
`default_nettype none
package ckt_pkg;

  localparam int unsigned SwW      = 22;  // switch vector field width
  localparam int unsigned PressW   = 7;
  localparam int unsigned RepW     = 15;
  localparam int unsigned StbW     = 24;
  localparam int unsigned ChordW   = 8;   // signed chord timer
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [1:0] {
    OP_SCAN = 2'd0,
    OP_TICK = 2'd1,
    OP_SLOW = 2'd2
  } op_e;

  localparam logic [CfgIdxW-1:0] CFG_PRESS_TICKS   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_TICKS = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_AUTOREP_TICKS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SLEEP_TICKS   = 3'd4;

  localparam logic [PressW-1:0] RST_PRESS_TICKS   = 7'd10;
  localparam logic [PressW-1:0] RST_RELEASE_TICKS = 7'd10;
  localparam logic [RepW-1:0]   RST_HOLD_TICKS    = 15'd1000;
  localparam logic [RepW-1:0]   RST_AUTOREP_TICKS = 15'd50;
  localparam logic [StbW-1:0]   RST_SLEEP_TICKS   = 24'd10000;

  localparam logic signed [ChordW-1:0] CHORD_SENT = -8'sd2;
  localparam logic signed [ChordW-1:0] CHORD_IDLE = -8'sd3;

  typedef struct packed {
    logic [PressW-1:0] press_ticks;
    logic [PressW-1:0] release_ticks;
    logic [RepW-1:0]   hold_ticks;
    logic [RepW-1:0]   autorep_ticks;
    logic [StbW-1:0]   sleep_ticks;
  } cfg_t;

  typedef struct packed {
    logic           send_now;
    logic [SwW-1:0] sent_vector;
    logic           quick_tap;
    logic           standby_due;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/ckt_core.sv
// Timer state registers and the single-pass next-state and result logic.
`default_nettype none
module ckt_core import ckt_pkg::*; #(
  parameter int unsigned NUM_SWITCHES = 22
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cfg_t           cfg_i,
  input  wire logic           take_i,
  input  wire logic [1:0]     operation_i,
  input  wire logic [SwW-1:0] switches_i,
  output      res_t           res_o
);

  localparam int unsigned VecW = (NUM_SWITCHES < SwW) ? NUM_SWITCHES : SwW;

  logic [VecW-1:0]          cur_q, cur_d, prev_q, prev_d;
  logic signed [ChordW-1:0] chord_q, chord_d;
  logic [RepW-1:0]          wait_q, wait_d, step_q, step_d;
  logic [StbW-1:0]          stby_q, stby_d;
  logic                     lwp_q, lwp_d;

  logic [VecW-1:0]          new_vec, rose, fell, vec;
  logic                     sent, tap;
  logic signed [ChordW-1:0] press_s, release_s;

  assign new_vec   = switches_i[VecW-1:0];
  assign rose      = new_vec & ~cur_q;
  assign fell      = cur_q & ~new_vec;
  assign press_s   = signed'({1'b0, cfg_i.press_ticks});
  assign release_s = signed'({1'b0, cfg_i.release_ticks});

  always_comb begin
    cur_d   = cur_q;
    prev_d  = prev_q;
    chord_d = chord_q;
    wait_d  = wait_q;
    step_d  = step_q;
    stby_d  = stby_q;
    lwp_d   = lwp_q;
    sent    = 1'b0;
    tap     = 1'b0;
    vec     = '0;
    unique case (op_e'(operation_i))
      OP_SCAN: begin
        prev_d = cur_q;
        cur_d  = new_vec;
        if (rose != '0) begin
          if (!lwp_q) chord_d = press_s;
          wait_d = cfg_i.hold_ticks;
          step_d = cfg_i.autorep_ticks;
          lwp_d  = 1'b1;
        end else if (fell != '0) begin
          if (lwp_q) begin
            // quick tap: chord timer still running, send the previous vector
            if (chord_q > 0) begin
              sent = 1'b1;
              tap  = 1'b1;
              vec  = prev_d;
            end
            chord_d = release_s;
          end
          wait_d = cfg_i.hold_ticks;
          step_d = cfg_i.autorep_ticks;
          lwp_d  = 1'b0;
        end
        if (!sent && (chord_d == '0 || step_d == '0)) begin
          sent    = 1'b1;
          vec     = new_vec;
          chord_d = CHORD_SENT;
          step_d  = cfg_i.autorep_ticks;
        end
      end
      OP_TICK: begin
        if (chord_q > 0) chord_d = chord_q - 8'sd1;
        if (cur_q != '0) begin
          stby_d = cfg_i.sleep_ticks;
          if (wait_q != '0) wait_d = wait_q - RepW'(1);
          else if (step_q != '0) step_d = step_q - RepW'(1);
        end
      end
      OP_SLOW: begin
        if (stby_q != '0) stby_d = stby_q - StbW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      prev_q  <= '0;
      chord_q <= CHORD_IDLE;
      wait_q  <= RST_HOLD_TICKS;
      step_q  <= RST_AUTOREP_TICKS;
      stby_q  <= '0;
      lwp_q   <= 1'b0;
    end else if (take_i) begin
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      chord_q <= chord_d;
      wait_q  <= wait_d;
      step_q  <= step_d;
      stby_q  <= stby_d;
      lwp_q   <= lwp_d;
    end
  end

  always_comb begin
    res_o.send_now    = sent;
    res_o.sent_vector = SwW'(vec);
    res_o.quick_tap   = tap;
    res_o.standby_due = (stby_d == '0);
  end

endmodule
`default_nettype wire

// File: rtl/core/ckt_skid.sv
// Result register with a skid stage so input is taken while a word waits.
`default_nettype none
module ckt_skid import ckt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t res_i,
  output      logic ready_o,
  output      logic valid_o,
  input  wire logic pop_ready_i,
  output      res_t res_o
);

  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;
  assign pop     = out_valid_q && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (push_i) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push_i) begin
      if (out_valid_q && !pop) skid_q <= res_i;
      else out_q <= res_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/chord_keyboard_timing_unit.sv
// Top level of the chord keyboard timing unit: config registers, core, output buffer.
//
//  - Input channel (in_valid_i / in_ready_o) carries one word per event:
//    operation_i selects scan (switch vector in switches_i), 1 ms tick or
//    slow tick; the unused operation code changes nothing.
//  - Output channel (out_valid_o / out_ready_i) returns exactly one word for
//    every input word, in order: send flag, vector sent, quick-tap flag and
//    standby-due flag.
//  - Each accepted word's result is registered in the result register or the skid
//    entry. One word per cycle is sustained while out_ready_i is high: the state
//    update and result are one pass of logic ahead of the result register.
//  - A two-entry output buffer (result register plus skid) lets a new word in
//    while a result waits; in_ready_o drops only when both entries are full,
//    so a stalled receiver holds the input back after two words.
//  - Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//    (0 press delay, 1 release delay, 2 repeat delay, 3 repeat period,
//    4 standby delay) at the clock edge; write only while idle.
//  - Reset (rst_ni low, asynchronous) restores register defaults 10, 10,
//    1000, 50, 10000, clears vectors, sets the chord timer to not pressed
//    and empties the output buffer.
`default_nettype none
module chord_keyboard_timing_unit import ckt_pkg::*; #(
  parameter int unsigned NUM_SWITCHES = 22
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic [1:0]          operation_i,
  input  wire logic [SwW-1:0]      switches_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic                send_now_o,
  output      logic [SwW-1:0]      sent_vector_o,
  output      logic                quick_tap_o,
  output      logic                standby_due_o
);

  cfg_t cfg_q;
  res_t core_res, buf_res;
  logic take;

  // config registers, truncated to their field widths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_ticks   <= RST_PRESS_TICKS;
      cfg_q.release_ticks <= RST_RELEASE_TICKS;
      cfg_q.hold_ticks    <= RST_HOLD_TICKS;
      cfg_q.autorep_ticks <= RST_AUTOREP_TICKS;
      cfg_q.sleep_ticks   <= RST_SLEEP_TICKS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRESS_TICKS:   cfg_q.press_ticks   <= cfg_data_i[PressW-1:0];
        CFG_RELEASE_TICKS: cfg_q.release_ticks <= cfg_data_i[PressW-1:0];
        CFG_HOLD_TICKS:    cfg_q.hold_ticks    <= cfg_data_i[RepW-1:0];
        CFG_AUTOREP_TICKS: cfg_q.autorep_ticks <= cfg_data_i[RepW-1:0];
        CFG_SLEEP_TICKS:   cfg_q.sleep_ticks   <= cfg_data_i[StbW-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  assign take = in_valid_i && in_ready_o;

  ckt_core #(
    .NUM_SWITCHES(NUM_SWITCHES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .take_i     (take),
    .operation_i(operation_i),
    .switches_i (switches_i),
    .res_o      (core_res)
  );

  ckt_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (take),
    .res_i      (core_res),
    .ready_o    (in_ready_o),
    .valid_o    (out_valid_o),
    .pop_ready_i(out_ready_i),
    .res_o      (buf_res)
  );

  assign send_now_o    = buf_res.send_now;
  assign sent_vector_o = buf_res.sent_vector;
  assign quick_tap_o   = buf_res.quick_tap;
  assign standby_due_o = buf_res.standby_due;

endmodule
`default_nettype wire
